// File: sv/advertiser_table_with_aging_assert.svh
// ---------------------------------------------------------------------------
// advertiser table assertion macros
// shared property forms for the advertiser table checks
// ---------------------------------------------------------------------------
`ifndef ADVERTISER_TABLE_WITH_AGING_ASSERT_SVH
`define ADVERTISER_TABLE_WITH_AGING_ASSERT_SVH

// expression holds at every clock edge out of reset
`define AVT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("advertiser table check failed");

// consequent holds in the cycle after the antecedent
`define AVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("advertiser table check failed");

`endif

// File: sv/avt_pkg.sv
// ---------------------------------------------------------------------------
// avt_pkg
// types and constants of the advertiser table
// ---------------------------------------------------------------------------
package avt_pkg;

    localparam int          TABLE_ENTRIES_DEF = 32;
    localparam logic [31:0] STALE_AGE_RESET   = 32'd300000;
    localparam int          OUT_CNT_W         = 6;

    typedef enum logic [1:0] {
        KIND_REPORT = 2'd0,
        KIND_SWEEP  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_UPDATED = 3'd0,
        ST_INSERTED = 3'd1,
        ST_DROPPED = 3'd2,
        ST_SWEPT   = 3'd3,
        ST_READ    = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [47:0]        address;
        logic signed [7:0]  rssi;
        logic [31:0]        now_ms;
        logic [4:0]         slot;
    } item_t;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [47:0]        addr;
        logic signed [7:0]  strength;
        logic [31:0]        seen;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t                status;
        logic [OUT_CNT_W-1:0]   removed;
        logic [OUT_CNT_W-1:0]   occupancy;
        logic                   slot_valid;
        logic [47:0]            slot_address;
        logic signed [7:0]      slot_rssi;
        logic [31:0]            slot_seen_ms;
        logic                   slot_fresh;
    } res_t;

endpackage

// File: sv/avt_entry_ram.sv
// ---------------------------------------------------------------------------
// avt_entry_ram
// single write port, single registered read port entry store
// ---------------------------------------------------------------------------
module avt_entry_ram
    import avt_pkg::*;
#(
    parameter int DEPTH  = TABLE_ENTRIES_DEF,
    parameter int ADDR_W = 5
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  entry_t              wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output entry_t              rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/avt_engine.sv
// ---------------------------------------------------------------------------
// avt_engine
// per-item sequencer: walks the entry ram for reports and sweeps
// ---------------------------------------------------------------------------
`include "advertiser_table_with_aging_assert.svh"

module avt_engine
    import avt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] stale_age_ms,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WRITE = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    item_t                      item_reg, item_next;
    logic [TABLE_ENTRIES-1:0]   used_reg, used_next;
    logic [TABLE_ENTRIES-1:0]   fresh_reg, fresh_next;
    logic [CNT_W-1:0]           occ_reg, occ_next;
    logic [CNT_W-1:0]           removed_reg, removed_next;
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic                       hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]           hit_idx_reg, hit_idx_next;
    logic                       free_found_reg, free_found_next;
    logic [IDX_W-1:0]           free_idx_reg, free_idx_next;
    logic                       in_range_reg, in_range_next;
    status_t                    status_reg, status_next;
    logic                       slot_valid_reg, slot_valid_next;
    entry_t                     slot_entry_reg, slot_entry_next;
    logic                       slot_fresh_reg, slot_fresh_next;

    logic                       ram_wr_en;
    logic [IDX_W-1:0]           ram_wr_addr;
    entry_t                     ram_wr_data;
    logic [IDX_W-1:0]           ram_rd_addr;
    entry_t                     ram_rd_data;
    logic [31:0]                age;
    logic [IDX_W-1:0]           slot_idx;

    avt_entry_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign age      = item_reg.now_ms - ram_rd_data.seen;
    assign slot_idx = IDX_W'(item_reg.slot);

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        used_next       = used_reg;
        fresh_next      = fresh_reg;
        occ_next        = occ_reg;
        removed_next    = removed_reg;
        scan_idx_next   = scan_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        in_range_next   = in_range_reg;
        status_next     = status_reg;
        slot_valid_next = slot_valid_reg;
        slot_entry_next = slot_entry_reg;
        slot_fresh_next = slot_fresh_reg;

        ram_wr_en       = 1'b0;
        ram_wr_addr     = hit_found_reg ? hit_idx_reg : free_idx_reg;
        ram_wr_data     = '{addr: item_reg.address, strength: item_reg.rssi,
                            seen: item_reg.now_ms};
        ram_rd_addr     = scan_idx_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next       = in_item;
                    removed_next    = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    slot_valid_next = 1'b0;
                    slot_entry_next = '0;
                    slot_fresh_next = 1'b0;
                    unique case (in_item.kind)
                        KIND_REPORT, KIND_SWEEP: begin
                            ram_rd_addr   = '0;
                            scan_idx_next = '0;
                            state_next    = S_SCAN;
                        end
                        KIND_READ: begin
                            ram_rd_addr   = IDX_W'(in_item.slot);
                            in_range_next = (int'(in_item.slot) < TABLE_ENTRIES);
                            state_next    = S_READ;
                        end
                        KIND_CLEAR: begin
                            fresh_next  = '0;
                            status_next = ST_CLEARED;
                            state_next  = S_DONE;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // ram data for scan_idx_reg is on the read port now
                ram_rd_addr = (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + 1'b1;
                if (item_reg.kind == KIND_REPORT) begin
                    if (used_reg[scan_idx_reg]) begin
                        if (!hit_found_reg && ram_rd_data.addr == item_reg.address) begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = scan_idx_reg;
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx_reg;
                    end
                end else begin
                    if (used_reg[scan_idx_reg] && age > stale_age_ms) begin
                        used_next[scan_idx_reg]  = 1'b0;
                        fresh_next[scan_idx_reg] = 1'b0;
                        removed_next             = removed_reg + 1'b1;
                        occ_next                 = occ_reg - 1'b1;
                    end
                    status_next = ST_SWEPT;
                end
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = (item_reg.kind == KIND_REPORT) ? S_WRITE : S_DONE;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_WRITE: begin
                if (hit_found_reg) begin
                    ram_wr_en               = 1'b1;
                    fresh_next[hit_idx_reg] = 1'b1;
                    status_next             = ST_UPDATED;
                end else if (free_found_reg) begin
                    ram_wr_en                = 1'b1;
                    used_next[free_idx_reg]  = 1'b1;
                    fresh_next[free_idx_reg] = 1'b1;
                    occ_next                 = occ_reg + 1'b1;
                    status_next              = ST_INSERTED;
                end else begin
                    status_next = ST_DROPPED;
                end
                state_next = S_DONE;
            end
            S_READ: begin
                ram_rd_addr     = slot_idx;
                slot_valid_next = in_range_reg && used_reg[slot_idx];
                slot_entry_next = slot_valid_next ? ram_rd_data : '0;
                slot_fresh_next = slot_valid_next && fresh_reg[slot_idx];
                status_next     = ST_READ;
                state_next      = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            fresh_reg <= '0;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            fresh_reg <= fresh_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        removed_reg    <= removed_next;
        scan_idx_reg   <= scan_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        in_range_reg   <= in_range_next;
        status_reg     <= status_next;
        slot_valid_reg <= slot_valid_next;
        slot_entry_reg <= slot_entry_next;
        slot_fresh_reg <= slot_fresh_next;
    end

    assign res = '{status:       status_reg,
                   removed:      OUT_CNT_W'(removed_reg),
                   occupancy:    OUT_CNT_W'(occ_reg),
                   slot_valid:   slot_valid_reg,
                   slot_address: slot_entry_reg.addr,
                   slot_rssi:    slot_entry_reg.strength,
                   slot_seen_ms: slot_entry_reg.seen,
                   slot_fresh:   slot_fresh_reg};

    `AVT_ASSERT_ALWAYS(a_occ_tracks_used, aclk, aresetn, $countones(used_reg) == int'(occ_reg))
    `AVT_ASSERT_ALWAYS(a_fresh_only_used, aclk, aresetn, (fresh_reg & ~used_reg) == '0)
    `AVT_ASSERT_NEXT(a_clear_drops_fresh, aclk, aresetn, state_reg == S_IDLE && in_valid && in_item.kind == KIND_CLEAR, fresh_reg == '0)
    `AVT_ASSERT_NEXT(a_sweep_ends_scan, aclk, aresetn, state_reg == S_SCAN && scan_idx_reg == LAST_IDX && item_reg.kind == KIND_SWEEP, state_reg == S_DONE)

endmodule

// File: sv/advertiser_table_with_aging.sv
// ---------------------------------------------------------------------------
// advertiser_table_with_aging
// table of seen advertisers keyed by 48-bit address, with aging sweep
// ---------------------------------------------------------------------------
// One input transfer gives exactly one result transfer. Items are handled
// one at a time; the cost is set by the walk over the entry ram, which
// reads one slot per cycle through its single registered read port.
// Reports and sweeps walk every slot; reads and clears do not. The result
// sits in an output register, so s_tready comes back as soon as the
// result leaves the engine, even while m_tvalid waits on m_tready.
// stale_age_ms, reset to 300000 ms, is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, which
// the block does not enforce. Valid and fresh marks live in flip-flops
// cleared by reset, so no clearing pass is needed; address, strength and
// time stamp live in the ram.
module advertiser_table_with_aging
    import avt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,

    // configuration: stale age limit in ms
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,

    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // address[47:0], rssi[55:48], now_ms[87:56], slot[92:88]
    input  logic [1:0]   s_tuser,   // kind[1:0]

    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // removed[5:0], occupancy[11:6], slot_valid[12],
                                    // slot_address[60:13], slot_rssi[68:61],
                                    // slot_seen_ms[100:69], slot_fresh[101]
    output logic [2:0]   m_tuser    // status[2:0]
);

    logic [31:0] stale_age_reg;
    item_t       in_item;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    logic        m_valid_reg;
    res_t        m_res_reg;

    // age limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_age_reg <= STALE_AGE_RESET;
        end else if (cfg_wr_en) begin
            stale_age_reg <= cfg_wr_data;
        end
    end

    // unpack the input transfer
    assign in_item = '{kind:    kind_t'(s_tuser),
                       address: s_tdata[47:0],
                       rssi:    s_tdata[55:48],
                       now_ms:  s_tdata[87:56],
                       slot:    s_tdata[92:88]};

    avt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .stale_age_ms (stale_age_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_item      (in_item),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register: takes a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    // pack the result transfer
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {2'b00,
                       m_res_reg.slot_fresh,
                       m_res_reg.slot_seen_ms,
                       m_res_reg.slot_rssi,
                       m_res_reg.slot_address,
                       m_res_reg.slot_valid,
                       m_res_reg.occupancy,
                       m_res_reg.removed};

endmodule

// File: test/advertiser_table_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// advertiser_table_checker
// watches both streams, keeps its own copy of the advertiser table and
// compares every result transfer field by field with the predicted one
// ---------------------------------------------------------------------------
module advertiser_table_checker
    import avt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,   // address[47:0], rssi[55:48], now_ms[87:56], slot[92:88]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,   // removed[5:0], occupancy[11:6], slot_valid[12],
                                    // slot_address[60:13], slot_rssi[68:61],
                                    // slot_seen_ms[100:69], slot_fresh[101]
    input  logic [2:0]   m_tuser,   // status[2:0]
    output int           fail_count,
    output int           pending,
    output logic [31:0]  written_slots
);

    localparam int SLOTS = TABLE_ENTRIES_DEF;

    // shadow table
    logic               adv_used  [SLOTS];
    logic [47:0]        adv_addr  [SLOTS];
    logic signed [7:0]  adv_rssi  [SLOTS];
    logic [31:0]        adv_seen  [SLOTS];
    logic               adv_fresh [SLOTS];
    logic [31:0]        age_limit;
    logic [31:0]        ever_written;

    res_t queued_results[$];
    res_t want;

    function automatic res_t apply_table_op(kind_t op, logic [47:0] addr,
                                            logic signed [7:0] rssi,
                                            logic [31:0] now, logic [4:0] slot);
        res_t o;
        int hit;
        int free_idx;
        int freed;
        int used_cnt;
        logic [31:0] age;
        o = '0;
        freed = 0;
        case (op)
            KIND_REPORT: begin
                hit = -1;
                free_idx = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (adv_used[i]) begin
                        if (hit < 0 && adv_addr[i] == addr) hit = i;
                    end else if (free_idx < 0) begin
                        free_idx = i;
                    end
                end
                if (hit >= 0) begin
                    adv_rssi[hit]  = rssi;
                    adv_seen[hit]  = now;
                    adv_fresh[hit] = 1'b1;
                    o.status = ST_UPDATED;
                end else if (free_idx >= 0) begin
                    adv_used[free_idx]     = 1'b1;
                    adv_addr[free_idx]     = addr;
                    adv_rssi[free_idx]     = rssi;
                    adv_seen[free_idx]     = now;
                    adv_fresh[free_idx]    = 1'b1;
                    ever_written[free_idx] = 1'b1;
                    o.status = ST_INSERTED;
                end else begin
                    o.status = ST_DROPPED;
                end
            end
            KIND_SWEEP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    // wrapping difference, compared unsigned
                    age = now - adv_seen[i];
                    if (adv_used[i] && age > age_limit) begin
                        adv_used[i]  = 1'b0;
                        adv_fresh[i] = 1'b0;
                        freed++;
                    end
                end
                o.status = ST_SWEPT;
            end
            KIND_READ: begin
                o.status = ST_READ;
                if (int'(slot) < SLOTS && adv_used[slot]) begin
                    o.slot_valid   = 1'b1;
                    o.slot_address = adv_addr[slot];
                    o.slot_rssi    = adv_rssi[slot];
                    o.slot_seen_ms = adv_seen[slot];
                    o.slot_fresh   = adv_fresh[slot];
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) adv_fresh[i] = 1'b0;
                o.status = ST_CLEARED;
            end
        endcase
        used_cnt = 0;
        for (int i = 0; i < SLOTS; i++) used_cnt += adv_used[i] ? 1 : 0;
        o.removed   = freed[OUT_CNT_W-1:0];
        o.occupancy = used_cnt[OUT_CNT_W-1:0];
        return o;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                adv_used[i]  = 1'b0;
                adv_fresh[i] = 1'b0;
            end
            age_limit     = STALE_AGE_RESET;
            ever_written  = '0;
            queued_results.delete();
            fail_count    = 0;
            pending       = 0;
            written_slots <= '0;
        end else begin
            if (cfg_wr_en) age_limit = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (queued_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, m_tuser);
                    fail_count++;
                end else begin
                    want = queued_results.pop_front();
                    check_field("status",       64'(want.status),       64'(m_tuser));
                    check_field("removed",      64'(want.removed),      64'(m_tdata[5:0]));
                    check_field("occupancy",    64'(want.occupancy),    64'(m_tdata[11:6]));
                    check_field("slot_valid",   64'(want.slot_valid),   64'(m_tdata[12]));
                    check_field("slot_address", 64'(want.slot_address), 64'(m_tdata[60:13]));
                    check_field("slot_rssi",    {56'd0, want.slot_rssi},
                                64'(m_tdata[68:61]));
                    check_field("slot_seen_ms", 64'(want.slot_seen_ms), 64'(m_tdata[100:69]));
                    check_field("slot_fresh",   64'(want.slot_fresh),   64'(m_tdata[101]));
                end
            end
            if (s_tvalid && s_tready) begin
                queued_results.insert(queued_results.size(),
                                      apply_table_op(kind_t'(s_tuser), s_tdata[47:0],
                                                     s_tdata[55:48], s_tdata[87:56],
                                                     s_tdata[92:88]));
            end
            pending       = queued_results.size();
            written_slots <= ever_written;
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the advertiser table with aging
// ---------------------------------------------------------------------------
// A short directed sequence covers the field extremes, every operation,
// wrapping ages, a freed slot being refilled and a zero age limit. Then
// random phases run under several age limits (extremes included): most
// reports draw from a pool of 40 addresses so that updates, a full table
// and dropped reports all show up, mixed with sweeps, reads of slots that
// have been filled at least once, and clears. Both streams stall in random
// bursts except in the last phase. The checker predicts and compares.
module tb;
    import avt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 115;
    localparam int POOL_SIZE      = 40;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         cfg_wr_en     = 1'b0;
    logic [31:0]  cfg_wr_data   = '0;
    logic         s_tvalid      = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata       = '0;  // address[47:0], rssi[55:48], now_ms[87:56], slot[92:88]
    logic [1:0]   s_tuser       = '0;  // kind[1:0]
    logic         m_tvalid;
    logic         m_tready      = 1'b0;
    logic [103:0] m_tdata;             // removed[5:0], occupancy[11:6], slot_valid[12],
                                       // slot_address[60:13], slot_rssi[68:61],
                                       // slot_seen_ms[100:69], slot_fresh[101]
    logic [2:0]   m_tuser;             // status[2:0]

    int           fail_count;
    int           pending;
    logic [31:0]  written_slots;

    // stimulus side state
    logic         idle_on       = 1'b1;
    logic [31:0]  clock_ms      = '0;
    logic [31:0]  age_cfg       = STALE_AGE_RESET;
    logic [47:0]  addr_pool [POOL_SIZE];
    logic [31:0]  phase_ages [6] = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd50000,
                                     32'd1000, 32'd300000};
    int           idle_cycles   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    advertiser_table_with_aging u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    advertiser_table_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .written_slots (written_slots)
    );

    // watchdog: cycles with no transfer on either stream
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL advertiser_table_with_aging");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts, none once idle_on drops
    initial begin
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // one input transfer; returns at the accepting edge with tvalid still high
    task automatic send_item(kind_t op, logic [47:0] addr, logic signed [7:0] rssi,
                             logic [31:0] now, logic [4:0] slot);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {3'b000, slot, now, rssi, addr};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // write the age limit once every result is out
    task automatic set_age_limit(logic [31:0] limit);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        age_cfg     = limit;
    endtask

    task automatic send_random_item();
        int          pick;
        logic [31:0] step_cap;
        logic [47:0] addr;
        logic [31:0] now;
        logic [4:0]  slot;
        kind_t       op;
        // advance the time stamp: mostly small steps, some around the limit,
        // now and then a jump anywhere (wraps included)
        step_cap = (age_cfg > 32'd400000) ? 32'd400000 : age_cfg + 32'd2;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(0, 40);
            6, 7, 8:          clock_ms = clock_ms + $urandom_range(0, step_cap);
            default:          clock_ms = clock_ms + $urandom;
        endcase
        // fields a kind ignores get random noise
        addr = 48'({$urandom, $urandom});
        now  = $urandom;
        slot = 5'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            op  = KIND_REPORT;
            now = clock_ms;
            if ($urandom_range(0, 3) != 0) addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 72) begin
            op = KIND_SWEEP;
            if ($urandom_range(0, 9) != 0) now = clock_ms;
        end else if (pick < 92 && written_slots != '0) begin
            // only slots that have held an entry at some point
            op = KIND_READ;
            while (!written_slots[slot]) slot = slot + 5'd1;
        end else begin
            op = KIND_CLEAR;
        end
        send_item(op, addr, 8'($urandom), now, slot);
    endtask

    initial begin
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = 48'({$urandom, $urandom});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset age limit of 300000 ms
        send_item(KIND_CLEAR,  48'h0, 8'sd0, 32'd0, 5'd0);              // empty table
        send_item(KIND_SWEEP,  48'h0, 8'sd0, 32'd0, 5'd0);
        send_item(KIND_REPORT, 48'h0, -8'sd128, 32'd0, 5'd0);           // insert slot 0
        send_item(KIND_REPORT, '1, 8'sd127, 32'hFFFF_FFFF, 5'd0);       // insert slot 1
        send_item(KIND_REPORT, 48'h0, 8'sd0, 32'd10, 5'd0);             // update slot 0
        send_item(KIND_READ,   48'h0, 8'sd0, 32'd0, 5'd0);
        send_item(KIND_READ,   48'h0, 8'sd0, 32'd0, 5'd1);
        send_item(KIND_CLEAR,  48'h0, 8'sd0, 32'd0, 5'd0);
        send_item(KIND_READ,   48'h0, 8'sd0, 32'd0, 5'd0);              // fresh mark gone
        // slot 0 exactly at the limit stays, slot 1 ages across the wrap
        send_item(KIND_SWEEP,  48'h0, 8'sd0, 32'd300010, 5'd0);
        send_item(KIND_READ,   48'h0, 8'sd0, 32'd0, 5'd1);              // freed slot
        send_item(KIND_REPORT, 48'h5555_5555_5555, -8'sd1, 32'd300010, 5'd0); // refill slot 1
        send_item(KIND_REPORT, 48'hAAAA_AAAA_AAAA, 8'sd1, 32'd300011, 5'd0);
        send_item(KIND_READ,   48'h0, 8'sd0, 32'd0, 5'd2);

        // zero age limit: only entries stamped exactly now survive
        set_age_limit(32'd0);
        send_item(KIND_SWEEP,  48'h0, 8'sd0, 32'd300010, 5'd0);
        send_item(KIND_READ,   48'h0, 8'sd0, 32'd0, 5'd1);
        send_item(KIND_SWEEP,  48'h0, 8'sd0, 32'd300011, 5'd0);
        send_item(KIND_READ,   48'h0, 8'sd0, 32'd0, 5'd2);
        clock_ms = 32'd300011;

        // random phases, one per age limit; the last runs without stalls
        for (int p = 0; p < 6; p++) begin
            set_age_limit(phase_ages[p]);
            if (p == 5) idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS advertiser_table_with_aging");
        end else begin
            $display("FAIL advertiser_table_with_aging");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/avt_pkg.sv
sv/avt_entry_ram.sv
sv/avt_engine.sv
sv/advertiser_table_with_aging.sv
test/advertiser_table_checker.sv
test/tb.sv
